[rtl/krck_pkg.sv]
`timescale 1ns / 1ps

package krck_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KEY_W       = 16;
    localparam int unsigned ROUND_W     = 5;
    localparam int unsigned ECHO_W      = 5;
    localparam int unsigned EXP_LEN_W   = 7;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_LEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LEN = 2'd1;

    localparam logic [ECHO_W-1:0]    ECHO_LEN_RESET     = 5'd4;
    localparam logic [EXP_LEN_W-1:0] EXPECTED_LEN_RESET = 7'd6;

    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [BYTE_W-1:0] SEED_HIGH_POS = 8'd3;
    localparam logic [BYTE_W-1:0] SEED_LOW_POS  = 8'd4;

    typedef enum logic [1:0] {
        FS_OK       = 2'd0,
        FS_EMPTY    = 2'd1,
        FS_LEN_ERR  = 2'd2,
        FS_CSUM_ERR = 2'd3
    } frame_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic byte_en;
        logic key_load;
        logic key_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic round_last;
        logic rounds_zero;
    } dp_status_t;

    function automatic logic [KEY_W-1:0] key_round(input logic [KEY_W-1:0] w);
        logic             fb;
        logic [KEY_W-1:0] nxt;
        fb  = w[1] ^ w[2] ^ w[8] ^ w[9];
        nxt = {fb, w[KEY_W-1:1]};
        nxt[0] = ~(w[3] & w[13]);
        return nxt;
    endfunction

    function automatic logic [ROUND_W-1:0] round_count(input logic [KEY_W-1:0] q);
        return {1'b0, q[15], q[7], q[4], q[0]} + 5'd1;
    endfunction

endpackage

[rtl/kline_response_check_keygen.sv]
`timescale 1ns / 1ps

// K-Line response window checker with seed-to-key generation.
// Input channel (s_valid/s_ready): one beat per received line byte
// (s_req_type = 0, byte on s_rx_byte) or a window-close beat (s_req_type = 1).
// The first echo_len bytes of a window are dropped as line echo; the rest are
// counted, summed and bytes 3 and 4 held as the seed.
// Result channel (m_valid/m_ready): one beat per close beat carrying the frame
// status, captured byte count and 16-bit key; byte beats give no result.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 writes echo_len,
// index 1 expected_len; other indexes are ignored. Write only while idle.
// Sequencing: a byte beat is taken while idle. A close beat loads the seed, then
// runs 1 to 16 key rounds (one round per cycle in the shift-feedback unit), then
// registers the result, which raises m_valid.
// The result sits in an output register: byte beats are taken while it waits,
// a further close beat runs its rounds and then holds until m_ready frees it.
// Reset: echo_len = 4, expected_len = 6, window and key state cleared,
// no result pending, input ready on the first cycle after reset.
module kline_response_check_keygen (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [krck_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_frame_status,
    output logic [krck_pkg::BYTE_W-1:0]         m_resp_count,
    output logic [krck_pkg::KEY_W-1:0]          m_key,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [krck_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [krck_pkg::CFG_DATA_W-1:0]     cfg_data
);

    krck_pkg::dp_cmd_t    cmd;
    krck_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    krck_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    krck_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .rx_byte      (s_rx_byte),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_status (m_frame_status),
        .resp_count   (m_resp_count),
        .key          (m_key)
    );

endmodule

[rtl/krck_ctrl.sv]
`timescale 1ns / 1ps

module krck_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  krck_pkg::dp_status_t  status,
    output krck_pkg::dp_cmd_t     cmd
);

    krck_pkg::ctrl_state_t state_reg;
    krck_pkg::ctrl_state_t state_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= krck_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            krck_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type) begin
                        cmd.key_load = 1'b1;
                        state_next   = krck_pkg::ST_ROUND;
                    end else begin
                        cmd.byte_en = 1'b1;
                    end
                end
            end
            krck_pkg::ST_ROUND: begin
                cmd.key_step = 1'b1;
                if (status.round_last) begin
                    state_next = krck_pkg::ST_FINISH;
                end
            end
            krck_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = krck_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = krck_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_close_starts_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type |=> state_reg == krck_pkg::ST_ROUND)
        else $error("close beat did not start key rounds");

    a_finish_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_valid_reg || m_ready)
        else $error("result overwritten while still pending");

    a_finish_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.rounds_zero)
        else $error("result taken before key rounds completed");

endmodule

[rtl/krck_dp.sv]
`timescale 1ns / 1ps

module krck_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  krck_pkg::dp_cmd_t                      cmd,
    output krck_pkg::dp_status_t                   status,
    input  logic [krck_pkg::BYTE_W-1:0]            rx_byte,
    input  logic                                   cfg_we,
    input  logic [krck_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [krck_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic [1:0]                             frame_status,
    output logic [krck_pkg::BYTE_W-1:0]            resp_count,
    output logic [krck_pkg::KEY_W-1:0]             key
);

    logic [krck_pkg::ECHO_W-1:0]    echo_len_reg;
    logic [krck_pkg::EXP_LEN_W-1:0] expected_len_reg;
    logic [krck_pkg::BYTE_W-1:0]    raw_count_reg;
    logic [krck_pkg::BYTE_W-1:0]    captured_count_reg;
    logic [krck_pkg::BYTE_W-1:0]    running_sum_reg;
    logic [krck_pkg::BYTE_W-1:0]    last_byte_reg;
    logic [krck_pkg::BYTE_W-1:0]    seed_high_reg;
    logic [krck_pkg::BYTE_W-1:0]    seed_low_reg;
    logic [krck_pkg::KEY_W-1:0]     key_work_reg;
    logic [krck_pkg::ROUND_W-1:0]   rounds_left_reg;
    logic [1:0]                     frame_status_reg;
    logic [krck_pkg::BYTE_W-1:0]    resp_count_reg;
    logic [krck_pkg::KEY_W-1:0]     key_reg;

    logic                           capture;
    logic [krck_pkg::KEY_W-1:0]     seed;
    logic [krck_pkg::BYTE_W-1:0]    sum_before_last;
    krck_pkg::frame_status_t        status_next;

    assign capture         = raw_count_reg >= {3'b000, echo_len_reg};
    assign seed            = {seed_high_reg, seed_low_reg};
    assign sum_before_last = running_sum_reg - last_byte_reg;

    always_comb begin
        if (captured_count_reg == '0) begin
            status_next = krck_pkg::FS_EMPTY;
        end else if (captured_count_reg != {1'b0, expected_len_reg}) begin
            status_next = krck_pkg::FS_LEN_ERR;
        end else if (sum_before_last != last_byte_reg) begin
            status_next = krck_pkg::FS_CSUM_ERR;
        end else begin
            status_next = krck_pkg::FS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_len_reg     <= krck_pkg::ECHO_LEN_RESET;
            expected_len_reg <= krck_pkg::EXPECTED_LEN_RESET;
        end else if (cfg_we) begin
            if (cfg_index == krck_pkg::CFG_ECHO_LEN) begin
                echo_len_reg <= cfg_data[krck_pkg::ECHO_W-1:0];
            end else if (cfg_index == krck_pkg::CFG_EXPECTED_LEN) begin
                expected_len_reg <= cfg_data[krck_pkg::EXP_LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_count_reg      <= '0;
            captured_count_reg <= '0;
            running_sum_reg    <= '0;
            last_byte_reg      <= '0;
            seed_high_reg      <= '0;
            seed_low_reg       <= '0;
            key_work_reg       <= '0;
            rounds_left_reg    <= '0;
        end else begin
            if (cmd.byte_en) begin
                if (capture) begin
                    if (captured_count_reg == krck_pkg::SEED_HIGH_POS) begin
                        seed_high_reg <= rx_byte;
                    end else if (captured_count_reg == krck_pkg::SEED_LOW_POS) begin
                        seed_low_reg <= rx_byte;
                    end
                    running_sum_reg <= running_sum_reg + rx_byte;
                    last_byte_reg   <= rx_byte;
                    if (captured_count_reg != krck_pkg::COUNT_MAX) begin
                        captured_count_reg <= captured_count_reg + 8'd1;
                    end
                end
                if (raw_count_reg != krck_pkg::COUNT_MAX) begin
                    raw_count_reg <= raw_count_reg + 8'd1;
                end
            end
            if (cmd.key_load) begin
                key_work_reg    <= seed;
                rounds_left_reg <= krck_pkg::round_count(seed);
            end
            if (cmd.key_step) begin
                key_work_reg    <= krck_pkg::key_round(key_work_reg);
                rounds_left_reg <= rounds_left_reg - 5'd1;
            end
            if (cmd.finish) begin
                raw_count_reg      <= '0;
                captured_count_reg <= '0;
                running_sum_reg    <= '0;
                last_byte_reg      <= '0;
                seed_high_reg      <= '0;
                seed_low_reg       <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            frame_status_reg <= status_next;
            resp_count_reg   <= captured_count_reg;
            key_reg          <= key_work_reg;
        end
    end

    assign status.round_last  = rounds_left_reg == 5'd1;
    assign status.rounds_zero = rounds_left_reg == '0;
    assign frame_status       = frame_status_reg;
    assign resp_count         = resp_count_reg;
    assign key                = key_reg;

    a_load_nonzero_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.key_load |=> rounds_left_reg != '0 && rounds_left_reg <= 5'd16)
        else $error("round count out of range after load");

    a_step_only_when_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.key_step |-> rounds_left_reg != '0)
        else $error("key round with no rounds left");

    a_finish_clears_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> captured_count_reg == '0 && raw_count_reg == '0)
        else $error("window not cleared after result");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import krck_pkg::*;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int PLAN_COUNT    = 6;
    localparam int PLAN_BEATS    = 75;
    localparam int LONG_WINDOW   = 260;

    localparam int ECHO_PLAN[PLAN_COUNT]    = '{4, 0, 31, 2, 1, 0};
    localparam int REPLY_LEN_PLAN[PLAN_COUNT] = '{6, 1, 64, 0, 5, 8};

    typedef enum logic [1:0] {
        PACE_SEND_LIGHT,
        PACE_SEND_HEAVY,
        PACE_NONE
    } pace_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CLOSE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        frame_status_t      status;
        logic [BYTE_W-1:0]  count;
        logic [KEY_W-1:0]   key;
    } frame_report_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [BYTE_W-1:0]       data;
        logic [CFG_INDEX_W-1:0]  cfg_idx;
        logic                    typed;
        frame_report_t           report;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_req_type = 1'b0;
    logic [BYTE_W-1:0]       s_rx_byte = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_frame_status;
    logic [BYTE_W-1:0]       m_resp_count;
    logic [KEY_W-1:0]        m_key;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    kline_response_check_keygen dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_resp_count   (m_resp_count),
        .m_key          (m_key),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [ECHO_W-1:0]    echo_setting      = ECHO_LEN_RESET;
    logic [EXP_LEN_W-1:0] reply_len_setting = EXPECTED_LEN_RESET;
    logic [BYTE_W-1:0]    win_raw      = '0;
    logic [BYTE_W-1:0]    win_captured = '0;
    logic [BYTE_W-1:0]    win_sum      = '0;
    logic [BYTE_W-1:0]    win_last     = '0;
    logic [BYTE_W-1:0]    seed_hi      = '0;
    logic [BYTE_W-1:0]    seed_lo      = '0;

    frame_report_t pending_reports[$];
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            beats_sent = 0;
    int            cycle_count = 0;
    pace_t         pace = PACE_SEND_LIGHT;
    int            hold_requests = 0;
    int            holds_started = 0;
    int            hold_left = 0;

    function automatic logic [KEY_W-1:0] seed_to_key(input logic [KEY_W-1:0] seed);
        logic [KEY_W-1:0] w;
        logic             fb;
        int               rounds;
        w = seed;
        rounds = {seed[15], seed[7], seed[4], seed[0]} + 1;
        for (int i = 0; i < rounds; i++) begin
            fb = w[1] ^ w[2] ^ w[8] ^ w[9];
            w  = {fb, w[KEY_W-1:1]} & ~16'h0001 | {15'd0, ~(w[3] & w[13])};
        end
        return w;
    endfunction

    function automatic bit advance_window(input logic req, input logic [BYTE_W-1:0] data,
                                          output frame_report_t report);
        report = '0;
        if (req == REQ_BYTE) begin
            if (win_raw >= {3'b000, echo_setting}) begin
                if (win_captured == SEED_HIGH_POS)
                    seed_hi = data;
                else if (win_captured == SEED_LOW_POS)
                    seed_lo = data;
                win_sum  = win_sum + data;
                win_last = data;
                if (win_captured != COUNT_MAX)
                    win_captured = win_captured + 8'd1;
            end
            if (win_raw != COUNT_MAX)
                win_raw = win_raw + 8'd1;
            return 1'b0;
        end
        if (win_captured == 8'd0)
            report.status = FS_EMPTY;
        else if (win_captured != {1'b0, reply_len_setting})
            report.status = FS_LEN_ERR;
        else if (BYTE_W'(win_sum - win_last) != win_last)
            report.status = FS_CSUM_ERR;
        else
            report.status = FS_OK;
        report.count = win_captured;
        report.key   = seed_to_key({seed_hi, seed_lo});
        win_raw      = '0;
        win_captured = '0;
        win_sum      = '0;
        win_last     = '0;
        seed_hi      = '0;
        seed_lo      = '0;
        return 1'b1;
    endfunction

    task automatic send_beat(input logic req, input logic [BYTE_W-1:0] data,
                             input logic typed, input frame_report_t typed_report);
        frame_report_t predicted;
        int            pause_pct;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        pause_pct = (pace == PACE_SEND_LIGHT) ? 32 : (pace == PACE_SEND_HEAVY) ? 50 : 0;
        if ($urandom_range(99) < pause_pct) begin
            s_valid    <= 1'b0;
            s_req_type <= 1'($urandom);
            s_rx_byte  <= 8'($urandom);
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= data;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (advance_window(req, data, predicted))
            pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    task automatic settle_block();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ECHO_LEN:     echo_setting = value[ECHO_W-1:0];
            CFG_EXPECTED_LEN: reply_len_setting = value[EXP_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_window(input int n_echo, input int n_cap, input logic [BYTE_W-1:0] flip);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        repeat (n_echo) send_beat(REQ_BYTE, 8'($urandom), 1'b0, '0);
        for (int i = 0; i < n_cap; i++) begin
            b = (i == n_cap - 1) ? (sum ^ flip) : 8'($urandom);
            sum = sum + b;
            send_beat(REQ_BYTE, b, 1'b0, '0);
        end
        send_beat(REQ_CLOSE, 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_random_window();
        int                shape;
        int                n_echo;
        int                n_cap;
        logic [BYTE_W-1:0] flip;
        shape  = $urandom_range(99);
        n_echo = echo_setting;
        n_cap  = reply_len_setting;
        flip   = '0;
        if (shape < 12) begin
            flip = 8'($urandom_range(255, 1));
        end else if (shape < 24) begin
            n_cap = $urandom_range(reply_len_setting + 3);
        end else if (shape < 30) begin
            n_echo = $urandom_range(echo_setting);
            n_cap  = 0;
        end else if (shape < 36) begin
            n_echo = 0;
            n_cap  = $urandom_range(12);
        end
        send_window(n_echo, n_cap, flip);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_started != hold_requests) begin
            m_ready       <= 1'b0;
            holds_started <= hold_requests;
            hold_left     <= HOLD_CYCLES;
        end else begin
            case (pace)
                PACE_SEND_LIGHT: m_ready <= ($urandom_range(99) >= 50);
                PACE_SEND_HEAVY: m_ready <= ($urandom_range(99) >= 32);
                default:         m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        frame_report_t seen;
        frame_report_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{frame_status_t'(m_frame_status), m_resp_count, m_key};
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected report: status %0d count %0d key %04h",
                             seen.status, seen.count, seen.key);
            end else begin
                want = pending_reports.pop_front();
                if (seen.status !== want.status || seen.count !== want.count ||
                    seen.key !== want.key) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("report mismatch: expected %0d/%0d/%04h, got %0d/%0d/%04h",
                                 want.status, want.count, want.key,
                                 seen.status, seen.count, seen.key);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        row_kind_t prev_kind;
        int        budget_end;

        directed_rows.push_back('{ROW_CLOSE, 8'h00, CFG_ECHO_LEN, 1'b1,
                                  '{FS_EMPTY, 8'd0, 16'h0001}});
        directed_rows.push_back('{ROW_BYTE,  8'h00, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'hFF, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h80, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CLOSE, 8'hFF, CFG_ECHO_LEN, 1'b1,
                                  '{FS_EMPTY, 8'd0, 16'h0001}});
        directed_rows.push_back('{ROW_CFG,   8'hE0, CFG_ECHO_LEN,     1'b0, '0});
        directed_rows.push_back('{ROW_CFG,   8'h86, CFG_EXPECTED_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CFG,   8'hFF, CFG_SPARE_2,      1'b0, '0});
        directed_rows.push_back('{ROW_CFG,   8'h5A, CFG_SPARE_3,      1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h10, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h20, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h30, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h00, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h00, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h60, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CLOSE, 8'h00, CFG_ECHO_LEN, 1'b1, '{FS_OK, 8'd6, 16'h0001}});
        directed_rows.push_back('{ROW_BYTE,  8'h10, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h20, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h30, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h00, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h00, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h61, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CLOSE, 8'h00, CFG_ECHO_LEN, 1'b1,
                                  '{FS_CSUM_ERR, 8'd6, 16'h0001}});
        repeat (5) directed_rows.push_back('{ROW_BYTE, 8'hFF, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'hFB, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CLOSE, 8'hFF, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_BYTE,  8'h01, CFG_ECHO_LEN, 1'b0, '0});
        directed_rows.push_back('{ROW_CLOSE, 8'h00, CFG_ECHO_LEN, 1'b1,
                                  '{FS_LEN_ERR, 8'd1, 16'h0001}});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        prev_kind = ROW_BYTE;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_BYTE:  send_beat(REQ_BYTE, row.data, row.typed, row.report);
                ROW_CLOSE: send_beat(REQ_CLOSE, row.data, row.typed, row.report);
                default: begin
                    if (prev_kind != ROW_CFG)
                        settle_block();
                    write_register(row.cfg_idx, row.data);
                end
            endcase
            prev_kind = row.kind;
        end

        for (int s = 0; s < PLAN_COUNT; s++) begin
            settle_block();
            write_register(CFG_ECHO_LEN, {3'($urandom), 5'(ECHO_PLAN[s])});
            write_register(CFG_EXPECTED_LEN, {1'($urandom), 7'(REPLY_LEN_PLAN[s])});
            if ($urandom_range(1))
                write_register($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom));
            pace <= (s < 2) ? PACE_SEND_LIGHT : (s < 4) ? PACE_SEND_HEAVY : PACE_NONE;
            if (s == 1)
                hold_requests <= hold_requests + 1;
            budget_end = beats_sent + PLAN_BEATS;
            do send_random_window(); while (beats_sent < budget_end);
            if (s == PLAN_COUNT - 1)
                send_window(echo_setting, LONG_WINDOW, 8'h00);
        end

        settle_block();
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
